@@ src/vrrb_pkg.sv @@
package vrrb_pkg;

  localparam int RING_MAX_BYTES   = 65536;
  localparam int HANDLE_BYTES     = 4;
  localparam int CHUNK_MIN        = 2048;
  localparam int CHUNK_MAX        = 65536;
  localparam int DRAIN_MAX_CHUNKS = 33;
  localparam int CNT_W            = $clog2(DRAIN_MAX_CHUNKS + 1);
  localparam int PADDR_W          = 4;

  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_CHUNK  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;
  localparam logic [1:0] ST_MORE     = 2'd3;

  localparam logic [1:0] REG_RING    = 2'd0;
  localparam logic [1:0] REG_RESERVE = 2'd1;
  localparam logic [1:0] REG_CHUNK   = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] event_bytes;
    logic [15:0] target_handle;
    logic        send_everything;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [16:0] free_bytes;
    logic [15:0] handle_address;
    logic [15:0] handle_word;
    logic [15:0] chunk_address;
    logic [16:0] chunk_length;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [16:0] ring_eff;
    logic [14:0] reserve;
    logic [16:0] chunk_eff;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUERY,
    S_FREE,
    S_COMMIT,
    S_SETUP,
    S_CHUNK,
    S_FINAL,
    S_STATUS,
    S_UNUSED
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_QUERY,
    OP_FREE,
    OP_COMMIT,
    OP_SETUP,
    OP_CHUNK,
    OP_FINAL,
    OP_STATUS,
    OP_UNUSED
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       loop_more;
    logic       final_emit;
    logic       slot_free;
  } dp_stat_t;

endpackage

@@ src/vrrb_regs.sv @@
module vrrb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output vrrb_pkg::cfg_t                cfg
);
  import vrrb_pkg::*;

  logic [16:0] ring_r;
  logic [14:0] reserve_r;
  logic [16:0] chunk_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r    <= 17'(RING_MAX_BYTES);
      reserve_r <= 15'd8200;
      chunk_r   <= 17'd8192;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_RING:    ring_r    <= pwdata[16:0];
        REG_RESERVE: reserve_r <= pwdata[14:0];
        REG_CHUNK:   chunk_r   <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RING:    prdata = {15'd0, ring_r};
      REG_RESERVE: prdata = {17'd0, reserve_r};
      REG_CHUNK:   prdata = {15'd0, chunk_r};
      default:     prdata = '0;
    endcase
  end

  // clamped views used by the datapath
  always_comb begin
    cfg.ring_eff  = (ring_r > 17'(RING_MAX_BYTES)) ? 17'(RING_MAX_BYTES) : ring_r;
    cfg.reserve   = reserve_r;
    cfg.chunk_eff = chunk_r;
    if (chunk_r < 17'(CHUNK_MIN)) cfg.chunk_eff = 17'(CHUNK_MIN);
    if (chunk_r > 17'(CHUNK_MAX)) cfg.chunk_eff = 17'(CHUNK_MAX);
  end

endmodule

@@ src/vrrb_ctrl.sv @@
module vrrb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrrb_pkg::dp_stat_t stat,
  output vrrb_pkg::ctl_t     ctl
);
  import vrrb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op = OP_LATCH;
          unique case (stat.in_cmd)
            CMD_QUERY:  state_nxt = S_QUERY;
            CMD_COMMIT: state_nxt = S_FREE;
            CMD_DRAIN:  state_nxt = S_SETUP;
            default:    state_nxt = S_UNUSED;
          endcase
        end
      end
      S_QUERY: begin
        if (stat.slot_free) begin
          ctl.op    = OP_QUERY;
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        ctl.op    = OP_FREE;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.slot_free) begin
          ctl.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      S_SETUP: begin
        ctl.op    = OP_SETUP;
        state_nxt = S_CHUNK;
      end
      S_CHUNK: begin
        if (stat.loop_more) begin
          if (stat.slot_free) ctl.op = OP_CHUNK;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (stat.final_emit) begin
          if (stat.slot_free) begin
            ctl.op    = OP_FINAL;
            state_nxt = S_STATUS;
          end
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        if (stat.slot_free) begin
          ctl.op    = OP_STATUS;
          state_nxt = S_IDLE;
        end
      end
      S_UNUSED: begin
        if (stat.slot_free) begin
          ctl.op    = OP_UNUSED;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ src/vrrb_dp.sv @@
module vrrb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  vrrb_pkg::cfg_t     cfg,
  input  vrrb_pkg::ctl_t     ctl,
  output vrrb_pkg::dp_stat_t stat,
  input  vrrb_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vrrb_pkg::out_t     out_data
);
  import vrrb_pkg::*;

  logic signed [17:0] write_r, write_nxt;
  logic [16:0]        read_r, read_nxt;
  logic [17:0]        end_r, end_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r;

  in_t                in_r;
  out_t               out_r, out_nxt;
  logic               out_load;
  logic [16:0]        fr_r, fr_nxt;
  logic [17:0]        ep_r, ep_nxt;
  logic signed [17:0] wp_r, wp_nxt;
  logic [16:0]        ch_r, ch_nxt;
  logic [17:0]        size_r, size_nxt;
  logic               go_r, go_nxt;

  logic signed [18:0] w_s, r_s, e_s, ring_s, rsv_s, ch_s, wp_s, ep_s;
  logic signed [18:0] f_s, wsum_s, sz_s;
  logic signed [17:0] wn;
  logic [16:0]        fr;
  logic [15:0]        szr;
  logic [17:0]        size_set;
  logic               go_set;
  logic [17:0]        addend;
  logic [18:0]        rsum;
  logic               wrap;

  assign w_s    = {write_r[17], write_r};
  assign r_s    = {2'b00, read_r};
  assign e_s    = {1'b0, end_r};
  assign ring_s = {2'b00, cfg.ring_eff};
  assign rsv_s  = {4'b0000, cfg.reserve};
  assign ch_s   = {2'b00, cfg.chunk_eff};
  assign wp_s   = {wp_r[17], wp_r};
  assign ep_s   = {1'b0, ep_r};

  // free space, with normalisation of a parked write offset
  always_comb begin
    wn  = write_r;
    f_s = '0;
    if (w_s >= r_s) begin
      f_s = ring_s - w_s;
    end else if (!write_r[17]) begin
      f_s = r_s - w_s;
    end else if (end_r == '0) begin
      wn  = '0;
      f_s = ring_s;
    end else if (read_r == '0) begin
      f_s = '0;
    end else begin
      wn  = '0;
      f_s = r_s;
    end
    fr = f_s[18] ? '0 : f_s[16:0];
  end

  // record length: handle word plus event padded to 8 bytes
  assign szr    = ({1'b0, in_r.event_bytes} + 16'd7) & ~16'd7;
  assign wsum_s = w_s + 19'(HANDLE_BYTES) + {3'b000, szr};

  always_comb begin
    go_set = 1'b1;
    sz_s   = '0;
    if (w_s == r_s) begin
      go_set = 1'b0;
    end else if (w_s > r_s) begin
      sz_s = w_s - r_s;
      if (sz_s < ch_s && !in_r.send_everything) go_set = 1'b0;
    end else begin
      sz_s = e_s - r_s;
    end
    size_set = sz_s[18] ? '0 : sz_s[17:0];
  end

  assign addend = (ctl.op == OP_FINAL) ? size_r : {1'b0, ch_r};
  assign rsum   = {2'b00, read_r} + {1'b0, addend};
  assign wrap   = (rsum == {1'b0, ep_r}) && (wp_s < ep_s);

  assign stat.in_cmd     = in_data.command;
  assign stat.loop_more  = go_r && (size_r > {1'b0, ch_r})
                           && (cnt_r < CNT_W'(DRAIN_MAX_CHUNKS));
  assign stat.final_emit = go_r && (size_r <= {1'b0, ch_r})
                           && (in_r.send_everything || (wp_s < r_s));
  assign stat.slot_free  = !out_valid_r || out_ready;

  always_comb begin
    write_nxt = write_r;
    read_nxt  = read_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    fr_nxt    = fr_r;
    ep_nxt    = ep_r;
    wp_nxt    = wp_r;
    ch_nxt    = ch_r;
    size_nxt  = size_r;
    go_nxt    = go_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    case (ctl.op)
      OP_QUERY: begin
        write_nxt          = wn;
        out_load           = 1'b1;
        out_nxt.kind       = KIND_REPLY;
        out_nxt.status     = ST_OK;
        out_nxt.free_bytes = fr;
        out_nxt.last       = 1'b1;
      end
      OP_FREE: begin
        write_nxt = wn;
        fr_nxt    = fr;
      end
      OP_COMMIT: begin
        out_load           = 1'b1;
        out_nxt.kind       = KIND_REPLY;
        out_nxt.free_bytes = fr_r;
        out_nxt.last       = 1'b1;
        if (fr_r < {2'b00, cfg.reserve}) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.handle_address = write_r[15:0];
          out_nxt.handle_word    = in_r.target_handle;
          out_nxt.status         = (wsum_s > ring_s) ? ST_PAST_END : ST_OK;
          if (wsum_s > e_s) end_nxt = wsum_s[17:0];
          if (ring_s - wsum_s < rsv_s) begin
            write_nxt = (read_r == '0) ? '1 : '0;
          end else begin
            write_nxt = wsum_s[17:0];
          end
        end
      end
      OP_SETUP: begin
        ep_nxt   = end_r;
        wp_nxt   = write_r;
        ch_nxt   = cfg.chunk_eff;
        cnt_nxt  = '0;
        size_nxt = size_set;
        go_nxt   = go_set;
      end
      OP_CHUNK: begin
        out_load              = 1'b1;
        out_nxt.kind          = KIND_CHUNK;
        out_nxt.chunk_address = read_r[15:0];
        out_nxt.chunk_length  = ch_r;
        read_nxt              = wrap ? '0 : rsum[16:0];
        if (wrap) end_nxt = '0;
        size_nxt = size_r - {1'b0, ch_r};
        cnt_nxt  = cnt_r + 1'b1;
      end
      OP_FINAL: begin
        out_load              = 1'b1;
        out_nxt.kind          = KIND_CHUNK;
        out_nxt.chunk_address = read_r[15:0];
        out_nxt.chunk_length  = size_r[16:0];
        read_nxt              = wrap ? '0 : rsum[16:0];
        if (wrap) end_nxt = '0;
      end
      OP_STATUS: begin
        out_load     = 1'b1;
        out_nxt.kind = KIND_STATUS;
        out_nxt.last = 1'b1;
        if (go_r && !(wp_r[17] && end_r == '0) && (wp_s != r_s)) begin
          out_nxt.status = ST_MORE;
        end else begin
          out_nxt.status = ST_OK;
        end
      end
      OP_UNUSED: begin
        out_load     = 1'b1;
        out_nxt.kind = KIND_REPLY;
        out_nxt.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_r     <= '0;
      read_r      <= '0;
      end_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      write_r <= write_nxt;
      read_r  <= read_nxt;
      end_r   <= end_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LATCH) in_r <= in_data;
    if (out_load) out_r <= out_nxt;
    fr_r   <= fr_nxt;
    ep_r   <= ep_nxt;
    wp_r   <= wp_nxt;
    ch_r   <= ch_nxt;
    size_r <= size_nxt;
    go_r   <= go_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_park_only_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    write_r[17] |-> (&write_r))
    else $error("write offset negative but not parked");

  a_chunk_budget: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DRAIN_MAX_CHUNKS))
    else $error("drain chunk count beyond budget");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

@@ src/variable_record_ring_buffer.sv @@
// Channel | Ports                          | Moves
// in      | in_valid in_ready in_data      | one request (query, commit, drain)
// out     | out_valid out_ready out_data   | result items, last marks the final one
// cfg     | psel penable pwrite paddr ...  | register writes and reads, pready tied high
//
// Query: latch, then reply. Commit: latch, free space, then pointer update and reply.
// Drain: latch, setup, the chunk loop for full chunks, a step to leave the loop, then the
// final piece and status; the chunk loop is the limit.
// Reset: synchronous, clears offsets, control and output valid; no clearing pass.
// A stalled out channel holds the sequencer; in is taken again only when idle.
module variable_record_ring_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vrrb_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vrrb_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import vrrb_pkg::*;

  cfg_t     cfg;
  ctl_t     ctl;
  dp_stat_t stat;

  vrrb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  vrrb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctl       (ctl),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_variable_record_ring_buffer.sv @@
module tb_variable_record_ring_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import vrrb_pkg::*;

  localparam int          CLK_PERIOD      = 8;
  localparam int          TIMEOUT_NS      = 10_000_000;
  localparam int          TAIL_CYCLES     = 64;
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 60;
  localparam int          LONG_HOLD       = 400;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;

  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    in_t         req;
    bit          typed;
    out_t        want;
  } step_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  // model of the ring pointers and registers
  longint wr_off, rd_off, end_off;
  longint ring_reg, reserve_reg, chunk_reg;
  out_t   pending_replies[$];

  int unsigned fail_count, request_count, result_count, chunk_count;
  int unsigned full_count, past_end_count, reg_write_count;
  bit          calm;
  int unsigned sink_hold;

  variable_record_ring_buffer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint ring_size();
    return (ring_reg > RING_MAX_BYTES) ? longint'(RING_MAX_BYTES) : ring_reg;
  endfunction

  function automatic longint chunk_size();
    if (chunk_reg < CHUNK_MIN) return CHUNK_MIN;
    if (chunk_reg > CHUNK_MAX) return CHUNK_MAX;
    return chunk_reg;
  endfunction

  // free space with pointer normalisation; may unpark the write offset
  function automatic longint free_room();
    longint f;
    if (wr_off >= rd_off) begin
      f = ring_size() - wr_off;
    end else if (wr_off >= 0) begin
      f = rd_off - wr_off;
    end else if (end_off == 0) begin
      wr_off = 0;
      f = ring_size();
    end else if (rd_off == 0) begin
      f = 0;
    end else begin
      wr_off = 0;
      f = rd_off;
    end
    return (f < 0) ? 0 : f;
  endfunction

  function automatic void wrap_read(longint end_snap, longint wr_snap);
    if (rd_off == end_snap && wr_snap < end_snap) begin
      rd_off  = 0;
      end_off = 0;
    end
  endfunction

  function automatic out_t make_item(logic [1:0] kind, logic [1:0] st, longint fr,
                                     longint ha, longint hw, longint ca, longint cl);
    out_t o;
    o.kind           = kind;
    o.status         = st;
    o.free_bytes     = fr[16:0];
    o.handle_address = ha[15:0];
    o.handle_word    = hw[15:0];
    o.chunk_address  = ca[15:0];
    o.chunk_length   = cl[16:0];
    o.last           = 1'b0;
    return o;
  endfunction

  function automatic void compute_ring_reply(in_t r);
    out_t       res[$];
    out_t       item;
    longint     fr, addr, padded, end_snap, wr_snap, ch, remain;
    logic [1:0] st;
    int         cnt;
    bit         go, drain_all;
    case (r.command)
      CMD_QUERY: begin
        res.push_back(make_item(KIND_REPLY, ST_OK, free_room(), 0, 0, 0, 0));
      end
      CMD_COMMIT: begin
        fr = free_room();
        if (fr < reserve_reg) begin
          res.push_back(make_item(KIND_REPLY, ST_FULL, fr, 0, 0, 0, 0));
        end else begin
          addr   = wr_off;
          padded = ((longint'(r.event_bytes) + 7) / 8) * 8;
          wr_off = wr_off + HANDLE_BYTES + padded;
          if (wr_off > end_off) end_off = wr_off;
          st = (wr_off > ring_size()) ? ST_PAST_END : ST_OK;
          if (ring_size() - wr_off < reserve_reg) wr_off = (rd_off == 0) ? -1 : 0;
          res.push_back(make_item(KIND_REPLY, st, fr, addr, r.target_handle, 0, 0));
        end
      end
      CMD_DRAIN: begin
        drain_all = r.send_everything;
        end_snap  = end_off;
        wr_snap   = wr_off;
        ch        = chunk_size();
        remain    = 0;
        st        = ST_OK;
        go        = 1'b1;
        if (wr_snap == rd_off) begin
          go = 1'b0;
        end else if (wr_snap > rd_off) begin
          remain = wr_snap - rd_off;
          if (remain < ch && !drain_all) go = 1'b0;
        end else begin
          remain = end_snap - rd_off;
        end
        if (remain < 0) remain = 0;
        if (go) begin
          cnt = 0;
          while (remain > ch && cnt < DRAIN_MAX_CHUNKS) begin
            res.push_back(make_item(KIND_CHUNK, ST_OK, 0, 0, 0, rd_off, ch));
            cnt++;
            rd_off = rd_off + ch;
            wrap_read(end_snap, wr_snap);
            remain = remain - ch;
          end
          if (remain <= ch && (drain_all || wr_snap < rd_off)) begin
            res.push_back(make_item(KIND_CHUNK, ST_OK, 0, 0, 0, rd_off, remain));
            rd_off = rd_off + remain;
            wrap_read(end_snap, wr_snap);
          end
          rd_off = rd_off & 64'h1FFFF;
          if (wr_snap < 0 && end_off == 0) st = ST_OK;
          else if (wr_snap != rd_off) st = ST_MORE;
        end
        res.push_back(make_item(KIND_STATUS, st, 0, 0, 0, 0, 0));
      end
      default: begin
        res.push_back(make_item(KIND_REPLY, ST_OK, 0, 0, 0, 0, 0));
      end
    endcase
    foreach (res[i]) begin
      item      = res[i];
      item.last = (i == res.size() - 1);
      pending_replies.push_back(item);
    end
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic step_t req_step(logic [1:0] cmd, int ev, int h, bit drain_all);
    step_t s;
    s.is_reg                = 1'b0;
    s.reg_idx               = REG_RING;
    s.reg_val               = '0;
    s.req.command           = cmd;
    s.req.event_bytes       = 15'(ev);
    s.req.target_handle     = 16'(h);
    s.req.send_everything   = drain_all;
    s.typed                 = 1'b0;
    s.want                  = '0;
    return s;
  endfunction

  function automatic step_t reg_step(logic [1:0] idx, int val);
    step_t s;
    s         = req_step(CMD_QUERY, 0, 0, 1'b0);
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = 32'(val);
    return s;
  endfunction

  function automatic step_t known_step(step_t s, logic [1:0] st, int fr, int ha, int hw);
    step_t k;
    k           = s;
    k.typed     = 1'b1;
    k.want      = make_item(KIND_REPLY, st, fr, ha, hw, 0, 0);
    k.want.last = 1'b1;
    return k;
  endfunction

  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.command = CMD_COMMIT;
    else if (pick < 70) r.command = CMD_DRAIN;
    else if (pick < 95) r.command = CMD_QUERY;
    else                r.command = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 7)      r.event_bytes = 15'($urandom_range(0, 1024));
    else if (pick < 9) r.event_bytes = 15'($urandom_range(0, 16384));
    else               r.event_bytes = 15'($urandom_range(0, 32767));
    r.target_handle   = 16'($urandom);
    r.send_everything = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(in_t r);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    request_count++;
    compute_ring_reply(r);
  endtask

  // sender stops and waits for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RING:    ring_reg    = val & 32'h1FFFF;
      REG_RESERVE: reserve_reg = val & 32'h7FFF;
      REG_CHUNK:   chunk_reg   = val & 32'h1FFFF;
      default: ;
    endcase
    reg_write_count++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        result_count++;
        if (want.kind == KIND_CHUNK) chunk_count++;
        if (want.kind == KIND_REPLY && want.status == ST_FULL) full_count++;
        if (want.kind == KIND_REPLY && want.status == ST_PAST_END) past_end_count++;
        check_field("kind", want.kind, out_data.kind);
        check_field("status", want.status, out_data.status);
        check_field("free_bytes", want.free_bytes, out_data.free_bytes);
        check_field("handle_address", want.handle_address, out_data.handle_address);
        check_field("handle_word", want.handle_word, out_data.handle_word);
        check_field("chunk_address", want.chunk_address, out_data.chunk_address);
        check_field("chunk_length", want.chunk_length, out_data.chunk_length);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin : result_sink
    int unsigned gap;
    forever begin
      if (sink_hold != 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 16);
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    step_t steps[$];
    int    ring_val, reserve_val, chunk_val;

    ring_reg    = 65536;
    reserve_reg = 8200;
    chunk_reg   = 8192;
    wr_off      = 0;
    rd_off      = 0;
    end_off     = 0;

    steps.push_back(known_step(req_step(CMD_QUERY, 0, 0, 1'b0), ST_OK, 65536, 0, 0));
    steps.push_back(known_step(req_step(CMD_UNUSED, 'h7FFF, 'hFFFF, 1'b1), ST_OK, 0, 0, 0));
    steps.push_back(known_step(req_step(CMD_COMMIT, 0, 0, 1'b0), ST_OK, 65536, 0, 0));
    steps.push_back(known_step(req_step(CMD_COMMIT, 'h7FFF, 'hFFFF, 1'b0),
                               ST_OK, 65532, 4, 'hFFFF));
    steps.push_back(req_step(CMD_DRAIN, 0, 0, 1'b0));
    steps.push_back(req_step(CMD_DRAIN, 0, 0, 1'b1));
    steps.push_back(req_step(CMD_COMMIT, 16384, 'h1234, 1'b0));
    steps.push_back(req_step(CMD_COMMIT, 16384, 'h5678, 1'b1));
    steps.push_back(req_step(CMD_DRAIN, 0, 0, 1'b1));
    // fill to exactly 33 minimum chunks, park, then drain with the budget
    steps.push_back(reg_step(REG_RESERVE, 16));
    steps.push_back(reg_step(REG_CHUNK, 0));
    repeat (5) steps.push_back(req_step(CMD_COMMIT, 11264, 'hA5A5, 1'b0));
    steps.push_back(req_step(CMD_COMMIT, 11240, 'h5A5A, 1'b1));
    steps.push_back(known_step(req_step(CMD_QUERY, 0, 0, 1'b0), ST_OK, 0, 0, 0));
    steps.push_back(known_step(req_step(CMD_COMMIT, 8, 'h0F0F, 1'b0), ST_FULL, 0, 0, 0));
    steps.push_back(req_step(CMD_DRAIN, 0, 0, 1'b0));
    steps.push_back(req_step(CMD_QUERY, 0, 0, 1'b0));
    // overfill past the budget so a parked writer resumes behind the reader
    repeat (3) steps.push_back(req_step(CMD_COMMIT, 16384, 'hC3C3, 1'b0));
    steps.push_back(req_step(CMD_COMMIT, 'h7FFF, 'h3C3C, 1'b0));
    steps.push_back(req_step(CMD_DRAIN, 0, 0, 1'b1));
    steps.push_back(req_step(CMD_QUERY, 0, 0, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        settle();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        send_request(steps[i].req);
        if (steps[i].typed) begin
          void'(pending_replies.pop_back());
          pending_replies.push_back(steps[i].want);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin ring_val = 4096;   reserve_val = 16;    chunk_val = 2048;   end
        1: begin ring_val = 131071; reserve_val = 16384; chunk_val = 131071; end
        2: begin ring_val = 65536;  reserve_val = 8200;  chunk_val = 8192;   end
        3: begin ring_val = 4096;   reserve_val = 16384; chunk_val = 0;      end
        4: begin
          ring_val    = $urandom_range(4096, 65536);
          reserve_val = $urandom_range(16, 4096);
          chunk_val   = $urandom_range(2048, 16384);
        end
        default: begin
          ring_val    = 20000;
          reserve_val = $urandom_range(16, 2048);
          chunk_val   = $urandom_range(0, 65536);
        end
      endcase
      write_reg(REG_RING, ring_val);
      write_reg(REG_RESERVE, reserve_val);
      write_reg(REG_CHUNK, chunk_val);
      calm = (ph == 4);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 2 && k == 10) sink_hold = LONG_HOLD;
        else if (k != 0 && $urandom_range(0, 29) == 0) settle();
        send_request(random_request());
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d result items: %0d drain chunks, %0d full rejects, %0d past-end commits",
             request_count, result_count, chunk_count, full_count, past_end_count);
    $display("Register writes: %0d over %0d settings, including clamped and extreme values",
             reg_write_count, PHASES + 1);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
